// File: rtl/core/bu4_pkg.sv
package bu4_pkg;

  localparam int SRC_DIM_DEF = 256;
  localparam int UPSCALE_DEF = 4;

  localparam int COORD_W    = 10;
  localparam int SAMPLE_W   = 16;
  localparam int VALUE_W    = 22;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 24;
  localparam int WGT_W      = 9;
  localparam int FIFO_DEPTH = 8;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  // One memory access as seen by the accumulator, aligned with the RAM read data.
  typedef struct packed {
    logic             vld;
    cmd_t             cmd;
    logic             first;
    logic             last;
    logic [WGT_W-1:0] wgt;
  } tok_t;

endpackage

// File: rtl/core/bu4_ram.sv
module bu4_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/core/bu4_fifo.sv
module bu4_fifo #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign valid = (count != '0);
  assign rdata = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The issue credit must keep the queue from ever overflowing.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != DEPTH_C))
    else $error("result queue pushed while full");
`endif

endmodule

// File: rtl/core/bu4_mac.sv
module bu4_mac #(
  parameter int UPSCALE = bu4_pkg::UPSCALE_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bu4_pkg::tok_t              tok,
  input  logic [bu4_pkg::SAMPLE_W-1:0] rdata,
  output logic                       push,
  output logic [bu4_pkg::VALUE_W:0]  push_data
);

  localparam int D        = 2 * UPSCALE;
  localparam int DD       = D * D;
  localparam int ACC_W    = 26;
  localparam int NACC_W   = 24;
  localparam int RSH      = 30;
  localparam int RW       = 27;
  localparam int SCALE_SH = 6;
  localparam int QSH      = RSH - SCALE_SH;
  localparam int QW       = 26;
  localparam int PW       = NACC_W + RW;
  localparam int RMW      = 32;

  // Bias that keeps every partial sum non-negative.
  localparam logic [ACC_W-1:0] OFF = ACC_W'((1 << (bu4_pkg::SAMPLE_W - 1)) * DD);
  localparam logic [RW-1:0]    RECIP = RW'((64'd1 << RSH) / DD);
  localparam logic [RMW-1:0]   DD_R  = RMW'(DD);
  localparam logic [bu4_pkg::VALUE_W-1:0] VOFF =
    bu4_pkg::VALUE_W'((1 << (bu4_pkg::SAMPLE_W - 1)) << SCALE_SH);

  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W-1:0] acc_next;
  logic signed [ACC_W-1:0] acc;

  logic              v1;
  logic              rd1;
  logic [NACC_W-1:0] a1;
  logic [PW-1:0]     p;

  logic              v2;
  logic              rd2;
  logic [NACC_W-1:0] a2;
  logic [QW-1:0]     q2;
  logic [RMW-1:0]    rem;
  logic [QW-1:0]     qf;
  logic [bu4_pkg::VALUE_W-1:0] value;

  // Weighted accumulate, one neighbor per cycle.
  assign prod     = $signed(rdata) * $signed({1'b0, tok.wgt});
  assign acc_base = tok.first ? $signed(OFF) : acc;
  assign acc_next = acc_base + prod;

  // Reciprocal estimate of 64*acc/DD, low by at most one.
  assign p = PW'(a1) * PW'(RECIP);

  assign rem   = (RMW'(a2) << SCALE_SH) - RMW'(q2) * DD_R;
  assign qf    = (rem >= DD_R) ? q2 + 1'b1 : q2;
  assign value = bu4_pkg::VALUE_W'(qf) - VOFF;

  assign push      = v2;
  assign push_data = {rd2, rd2 ? value : {bu4_pkg::VALUE_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (tok.vld) begin
      acc <= acc_next;
    end
    a1 <= NACC_W'(acc_next);
    a2 <= a1;
    q2 <= p[QSH+QW-1:QSH];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      rd1 <= 1'b0;
      v2  <= 1'b0;
      rd2 <= 1'b0;
    end else begin
      v1  <= tok.vld && tok.last;
      rd1 <= (tok.cmd == bu4_pkg::CMD_READ);
      v2  <= v1;
      rd2 <= rd1;
    end
  end

`ifndef ASSERT_OFF
  // The reciprocal estimate may need at most one correction step.
  a_one_correction: assert property (@(posedge clk) disable iff (rst)
    (v2 && rd2) |-> (rem < (DD_R << 1)))
    else $error("reciprocal estimate off by more than one");
`endif

endmodule

// File: rtl/core/bu4_seq.sv
module bu4_seq #(
  parameter int SRC_DIM    = bu4_pkg::SRC_DIM_DEF,
  parameter int UPSCALE    = bu4_pkg::UPSCALE_DEF,
  parameter int FIFO_DEPTH = bu4_pkg::FIFO_DEPTH,
  localparam int AW        = $clog2(SRC_DIM * SRC_DIM)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bu4_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  input  logic                          pop,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_addr,
  output logic [bu4_pkg::SAMPLE_W-1:0]  ram_wdata,
  output bu4_pkg::tok_t                 tok
);

  localparam int D        = 2 * UPSCALE;
  localparam int FW       = $clog2(D);
  localparam int IW       = $clog2(SRC_DIM);
  localparam int NW       = bu4_pkg::COORD_W + 2;
  localparam int RSH      = 16;
  localparam int CW       = $clog2(FIFO_DEPTH + 1);
  localparam int WPW      = 2 * FW + 2;
  localparam logic [RSH-1:0] RECIP  = RSH'((1 << RSH) / D);
  localparam logic [NW-1:0]  D_N    = NW'(D);
  localparam logic [NW-1:0]  LAST_N = NW'(SRC_DIM - 1);
  localparam logic [bu4_pkg::COORD_W:0] DIM_C = (bu4_pkg::COORD_W + 1)'(SRC_DIM);
  localparam logic [AW-1:0]  DIM_A  = AW'(SRC_DIM);
  localparam logic [FW:0]    D_F    = (FW + 1)'(D);
  localparam logic [CW-1:0]  DEPTH_C = CW'(FIFO_DEPTH);
  localparam logic [1:0]     PH_LAST = 2'd3;

  typedef struct packed {
    logic [IW-1:0] lo;
    logic [IW-1:0] hi;
    logic [FW-1:0] frac;
  } loc_t;

  // Split an output coordinate into clamped neighbor indices and a fraction in 1/D.
  function automatic loc_t locate(input logic [bu4_pkg::COORD_W-1:0] o);
    logic [NW-1:0]     n;
    logic [NW+RSH-1:0] prod;
    logic [NW-1:0]     q;
    logic [NW-1:0]     r;
    logic [NW-1:0]     qm;
    loc_t              l;
    n    = NW'({o, 1'b1}) + NW'(UPSCALE);
    prod = (NW + RSH)'(n) * (NW + RSH)'(RECIP);
    q    = prod[NW+RSH-1:RSH];
    r    = n - q * D_N;
    if (r >= D_N) begin
      q = q + 1'b1;
      r = r - D_N;
    end
    qm     = q - 1'b1;
    l.hi   = (q > LAST_N) ? IW'(LAST_N) : IW'(q);
    l.lo   = (q == '0) ? '0 : ((qm > LAST_N) ? IW'(LAST_N) : IW'(qm));
    l.frac = FW'(r);
    return l;
  endfunction

  logic [bu4_pkg::COORD_W-1:0]  in_row;
  logic [bu4_pkg::COORD_W-1:0]  in_col;
  logic [bu4_pkg::SAMPLE_W-1:0] in_sample;
  bu4_pkg::cmd_t                in_cmd;
  loc_t                         ly;
  loc_t                         lx;

  logic                  busy;
  bu4_pkg::cmd_t         cmd;
  logic [1:0]            ph;
  logic [IW-1:0]         r0;
  logic [IW-1:0]         r1;
  logic [IW-1:0]         c0;
  logic [IW-1:0]         c1;
  logic [FW-1:0]         fy;
  logic [FW-1:0]         fx;
  logic                  ld_ok;
  logic [bu4_pkg::SAMPLE_W-1:0] sample;
  logic [CW-1:0]         cnt;

  logic                  finishing;
  logic                  accept;
  logic [IW-1:0]         sel_r;
  logic [IW-1:0]         sel_c;
  logic [FW:0]           wa;
  logic [FW:0]           wb;
  logic [WPW-1:0]        wprod;

  assign in_row    = s_tdata[bu4_pkg::COORD_W-1:0];
  assign in_col    = s_tdata[2*bu4_pkg::COORD_W-1:bu4_pkg::COORD_W];
  assign in_sample = s_tdata[2*bu4_pkg::COORD_W+bu4_pkg::SAMPLE_W-1:2*bu4_pkg::COORD_W];
  assign in_cmd    = bu4_pkg::cmd_t'(s_tuser);
  assign ly        = locate(in_row);
  assign lx        = locate(in_col);

  assign finishing = busy && ((cmd == bu4_pkg::CMD_LOAD) || (ph == PH_LAST));
  assign s_tready  = (cnt < DEPTH_C) && (!busy || finishing);
  assign accept    = s_tvalid && s_tready;

  // Phase order: (r0,c0) (r0,c1) (r1,c0) (r1,c1).
  assign sel_r     = ph[1] ? r1 : r0;
  assign sel_c     = ph[0] ? c1 : c0;
  assign ram_addr  = AW'(sel_r) * DIM_A + AW'(sel_c);
  assign ram_we    = busy && (cmd == bu4_pkg::CMD_LOAD) && ld_ok;
  assign ram_wdata = sample;

  assign wa    = ph[0] ? {1'b0, fx} : D_F - {1'b0, fx};
  assign wb    = ph[1] ? {1'b0, fy} : D_F - {1'b0, fy};
  assign wprod = WPW'(wa) * WPW'(wb);

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd    <= in_cmd;
      sample <= in_sample;
      ld_ok  <= ({1'b0, in_row} < DIM_C) && ({1'b0, in_col} < DIM_C);
      fy     <= ly.frac;
      fx     <= lx.frac;
      r1     <= ly.hi;
      c1     <= lx.hi;
      if (in_cmd == bu4_pkg::CMD_READ) begin
        r0 <= ly.lo;
        c0 <= lx.lo;
      end else begin
        r0 <= IW'(in_row);
        c0 <= IW'(in_col);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      ph   <= '0;
      cnt  <= '0;
      tok  <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        ph   <= '0;
      end else begin
        if (finishing) begin
          busy <= 1'b0;
        end
        if (busy) begin
          ph <= ph + 1'b1;
        end
      end
      case ({accept, pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
      tok.vld   <= busy;
      tok.cmd   <= cmd;
      tok.first <= (ph == '0);
      tok.last  <= finishing;
      tok.wgt   <= bu4_pkg::WGT_W'(wprod);
    end
  end

`ifndef ASSERT_OFF
  // A read holds the port and steps through its phases without a break.
  a_read_phases: assert property (@(posedge clk) disable iff (rst)
    (busy && (cmd == bu4_pkg::CMD_READ) && (ph != PH_LAST) && !accept)
      |=> (busy && (ph == $past(ph) + 2'd1)))
    else $error("read sequence broken");

  // A delivered result must have been counted against the credit.
  a_credit_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> (cnt != '0))
    else $error("result delivered with no item outstanding");

  // No new item may enter while a read is still fetching neighbors.
  a_no_overtake: assert property (@(posedge clk) disable iff (rst)
    (busy && (cmd == bu4_pkg::CMD_READ) && (ph != PH_LAST)) |-> !accept)
    else $error("item accepted during a read");
`endif

endmodule

// File: rtl/core/bilinear_upsample_x4.sv
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tuser: command; s_tdata: row, col, sample
// m_*       out  m_tvalid/m_tready  m_tuser: is_read; m_tdata: value
//
// The source map is one single-ported RAM: a load holds its port for one write,
// and a read fetches its four neighbors one per cycle.
// After an item's last map access its token and read data are registered, the
// v1 and v2 stages of bu4_mac follow, and the result is written into the queue.
// Reset clears control only; map contents stay undefined until loaded.
// Results wait in an 8-entry queue; input stalls once 8 items are outstanding.
// A load writes in its issue cycle and later reads issue after it, so no
// forwarding is needed.
module bilinear_upsample_x4 #(
  parameter int SRC_DIM = bu4_pkg::SRC_DIM_DEF,
  parameter int UPSCALE = bu4_pkg::UPSCALE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [9:0] row, [19:10] col, [35:20] sample, [39:36] zero
  input  logic [bu4_pkg::S_TDATA_W-1:0] s_tdata,
  // [0] command
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [21:0] value, [23:22] zero
  output logic [bu4_pkg::M_TDATA_W-1:0] m_tdata,
  // [0] is_read
  output logic                          m_tuser
);

  localparam int MAP_DEPTH = SRC_DIM * SRC_DIM;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int RES_W     = bu4_pkg::VALUE_W + 1;

  logic                         pop;
  logic                         ram_we;
  logic [MAP_AW-1:0]            ram_addr;
  logic [bu4_pkg::SAMPLE_W-1:0] ram_wdata;
  logic [bu4_pkg::SAMPLE_W-1:0] ram_rdata;
  bu4_pkg::tok_t                tok;
  logic                         push;
  logic [RES_W-1:0]             push_data;
  logic [RES_W-1:0]             res;

  assign pop = m_tvalid && m_tready;

  // Accept items, locate neighbors and drive the map port.
  bu4_seq #(
    .SRC_DIM    (SRC_DIM),
    .UPSCALE    (UPSCALE),
    .FIFO_DEPTH (bu4_pkg::FIFO_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .pop       (pop),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .tok       (tok)
  );

  // Source map, one sample per entry.
  bu4_ram #(
    .WIDTH (bu4_pkg::SAMPLE_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Weight, accumulate and scale to Q8.8 times 64.
  bu4_mac #(
    .UPSCALE (UPSCALE)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok),
    .rdata     (ram_rdata),
    .push      (push),
    .push_data (push_data)
  );

  // Hold finished results until the sink takes them.
  bu4_fifo #(
    .WIDTH (RES_W),
    .DEPTH (bu4_pkg::FIFO_DEPTH)
  ) u_res (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_data),
    .pop   (pop),
    .valid (m_tvalid),
    .rdata (res)
  );

  assign m_tdata = bu4_pkg::M_TDATA_W'(res[bu4_pkg::VALUE_W-1:0]);
  assign m_tuser = res[bu4_pkg::VALUE_W];

endmodule
